@@ rtl/whp_pkg.sv @@
// Shared types and constants for the RIFF/WAVE header parser.
// Used by the stream interface and the parser top level; no dependencies.
`default_nettype none

package whp_pkg;

   localparam int unsigned TICK_W   = 24;
   localparam int unsigned MIN_W    = 16;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_TICK_RATE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DATA  = 1'd1;

   localparam logic [TICK_W-1:0] TICK_RATE_RESET = 24'd2000000;
   localparam logic [MIN_W-1:0]  MIN_DATA_RESET  = 16'd1024;

   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [31:0] RATE_MIN = 32'd8000;
   localparam logic [31:0] RATE_MAX = 32'd48000;
   localparam logic [15:0] FMT_PCM  = 16'd1;
   localparam int unsigned FMT_MIN_BYTES = 16;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_IO_ERR  = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_file;
      logic       stream_end;
      logic       io_error;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  channels;
      logic [4:0]  bits_per_sample;
      logic [7:0]  sample_period;
      logic [31:0] data_size;
      logic [31:0] data_offset;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ rtl/whp_stream_if.sv @@
// Valid/ready stream channel carrying one item type.
// Depends on whp_pkg for the default item type.
`default_nettype none

interface whp_stream_if
   import whp_pkg::*;
#(
   parameter type item_type = req_item_type
) ();

   logic     valid;
   logic     ready;
   item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

@@ rtl/wav_header_parser_unit.sv @@
// RIFF/WAVE header parser top level: byte stream in, at most one verdict item per file out.
// Depends on whp_pkg and whp_stream_if.
//
// The parser takes one file byte per clock cycle. At the end of a valid fmt chunk it
// runs a restoring divider (tick_rate_hz / rate), one quotient bit per cycle, and takes
// no byte during that time. It also holds off new bytes while a finished verdict sits in
// the output register and the result side is stalled. Each file yields at most one
// result: io_error, stream_end, a bad header or fmt chunk, or the first data chunk
// ends the file; later bytes are consumed silently until new_file.
`default_nettype none

module wav_header_parser_unit
   import whp_pkg::*;
#(
   parameter int unsigned MAX_FMT_BYTES = 128
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   whp_stream_if.sink                req_bus,
   whp_stream_if.source              rsp_bus,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TICK_W-1:0]    csr_wdata
);

   localparam int unsigned CNT_W   = $clog2(MAX_FMT_BYTES + 1);
   localparam int unsigned DIV_W   = TICK_W;
   localparam int unsigned DCNT_W  = $clog2(DIV_W);
   localparam int unsigned DVSR_W  = 16;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_CHUNK,
      PH_FMT,
      PH_SKIP,
      PH_DIV
   } phase_type;

   phase_type          phase_ff,   phase_in;
   logic [CNT_W-1:0]   cnt_ff,     cnt_in;
   logic [31:0]        len_ff,     len_in;
   logic [31:0]        tag_ff,     tag_in;
   logic [31:0]        pos_ff,     pos_in;
   logic [2:0]         align_ff,   align_in;
   logic [15:0]        ftag_ff,    ftag_in;
   logic [15:0]        chans_ff,   chans_in;
   logic [31:0]        rate_ff,    rate_in;
   logic [15:0]        bits_ff,    bits_in;
   logic [7:0]         period_ff,  period_in;
   logic               verdict_ff, verdict_in;
   logic               pad_ff,     pad_in;

   logic [TICK_W-1:0]  tick_ff,    tick_in;
   logic [MIN_W-1:0]   min_ff,     min_in;

   logic [DVSR_W:0]    rem_ff,     rem_in;
   logic [DIV_W-1:0]   quo_ff,     quo_in;
   logic [DCNT_W-1:0]  dcnt_ff,    dcnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff,  rsp_item_in;

   logic               accept;
   logic               emit_valid;
   logic [1:0]         emit_status;
   logic [31:0]        emit_size;
   logic [31:0]        emit_offset;
   rsp_item_type       emit_item;

   assign req_bus.ready = (phase_ff != PH_DIV) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_item_ff;

   always_comb begin
      logic [DVSR_W:0]  shifted;
      logic             qbit;
      logic [DIV_W-1:0] quo_nx;
      logic [CNT_W-1:0] n;
      logic [CNT_W-1:0] n1;
      logic [7:0]       b;
      logic [31:0]      pos_nx;
      logic [31:0]      len_nx;
      logic [32:0]      rounded;
      logic [2:0]       mask;
      logic             fmt_ok;

      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      len_in       = len_ff;
      tag_in       = tag_ff;
      pos_in       = pos_ff;
      align_in     = align_ff;
      ftag_in      = ftag_ff;
      chans_in     = chans_ff;
      rate_in      = rate_ff;
      bits_in      = bits_ff;
      period_in    = period_ff;
      verdict_in   = verdict_ff;
      pad_in       = pad_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      tick_in      = tick_ff;
      min_in       = min_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_item_in  = rsp_item_ff;
      emit_valid   = 1'b0;
      emit_status  = STATUS_OK;
      emit_size    = '0;
      emit_offset  = '0;
      shifted      = '0;
      qbit         = 1'b0;
      quo_nx       = '0;
      n            = '0;
      n1           = '0;
      b            = req_bus.data.data_byte;
      pos_nx       = '0;
      len_nx       = '0;
      rounded      = '0;
      mask         = '0;
      fmt_ok       = 1'b0;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_TICK_RATE: tick_in = csr_wdata;
            CSR_MIN_DATA:  min_in  = csr_wdata[MIN_W-1:0];
            default:       ;
         endcase
      end

      if (phase_ff == PH_DIV) begin
         shifted = {rem_ff[DVSR_W-1:0], quo_ff[DIV_W-1]};
         qbit    = shifted >= {1'b0, rate_ff[DVSR_W-1:0]};
         rem_in  = qbit ? shifted - {1'b0, rate_ff[DVSR_W-1:0]} : shifted;
         quo_nx  = {quo_ff[DIV_W-2:0], qbit};
         quo_in  = quo_nx;
         dcnt_in = dcnt_ff - 1'b1;
         if (dcnt_ff == '0) begin
            period_in = quo_nx[7:0] - 8'd1;
            align_in  = (bits_ff == 16'd16) ? {chans_ff[1:0], 1'b0} : {1'b0, chans_ff[1:0]};
            phase_in  = PH_CHUNK;
            cnt_in    = '0;
         end
      end else if (accept) begin
         if (req_bus.data.new_file) begin
            phase_in   = PH_HEADER;
            cnt_in     = '0;
            len_in     = '0;
            tag_in     = '0;
            pos_in     = '0;
            align_in   = '0;
            ftag_in    = '0;
            chans_in   = '0;
            rate_in    = '0;
            bits_in    = '0;
            period_in  = '0;
            verdict_in = 1'b0;
            pad_in     = 1'b0;
         end
         if (!verdict_in) begin
            if (req_bus.data.io_error) begin
               emit_valid  = 1'b1;
               emit_status = STATUS_IO_ERR;
            end else if (req_bus.data.stream_end) begin
               emit_valid  = 1'b1;
               emit_status = STATUS_INVALID;
            end else begin
               n      = cnt_in;
               n1     = cnt_in + 1'b1;
               pos_nx = pos_in + 32'd1;
               pos_in = pos_nx;
               case (phase_in)
                  PH_HEADER: begin
                     if (n >= CNT_W'(8)) begin
                        tag_in = {b, tag_in[31:8]};
                     end
                     cnt_in = n1;
                     if (n == CNT_W'(11)) begin
                        if (tag_in != TAG_WAVE) begin
                           emit_valid  = 1'b1;
                           emit_status = STATUS_INVALID;
                        end else begin
                           phase_in = PH_CHUNK;
                           cnt_in   = '0;
                        end
                     end
                  end
                  PH_CHUNK: begin
                     if (n < CNT_W'(4)) begin
                        tag_in = {b, tag_in[31:8]};
                     end else begin
                        len_in = {b, len_in[31:8]};
                     end
                     cnt_in = n1;
                     if (n == CNT_W'(7)) begin
                        len_nx = len_in;
                        cnt_in = '0;
                        if (tag_in == TAG_FMT) begin
                           rounded = {1'b0, len_nx} + {32'd0, len_nx[0]};
                           if (rounded < 33'(FMT_MIN_BYTES) ||
                               rounded > 33'(MAX_FMT_BYTES)) begin
                              emit_valid  = 1'b1;
                              emit_status = STATUS_INVALID;
                           end else begin
                              len_in    = rounded[31:0];
                              align_in  = '0;
                              ftag_in   = '0;
                              chans_in  = '0;
                              rate_in   = '0;
                              bits_in   = '0;
                              period_in = '0;
                              phase_in  = PH_FMT;
                           end
                        end else if (tag_in == TAG_DATA) begin
                           mask        = align_in - 3'd1;
                           emit_valid  = 1'b1;
                           if (align_in == '0 || len_nx < {16'd0, min_in} ||
                               (len_nx[2:0] & mask) != '0 ||
                               (pos_nx[2:0] & mask) != '0) begin
                              emit_status = STATUS_INVALID;
                           end else begin
                              emit_status = STATUS_OK;
                              emit_size   = len_nx;
                              emit_offset = pos_nx;
                           end
                        end else begin
                           pad_in   = len_nx[0];
                           phase_in = (len_nx == '0) ? PH_CHUNK : PH_SKIP;
                        end
                     end
                  end
                  PH_FMT: begin
                     if (n == CNT_W'(0)) begin
                        ftag_in[7:0] = b;
                     end else if (n == CNT_W'(1)) begin
                        ftag_in[15:8] = b;
                     end else if (n == CNT_W'(2)) begin
                        chans_in[7:0] = b;
                     end else if (n == CNT_W'(3)) begin
                        chans_in[15:8] = b;
                     end else if (n < CNT_W'(8)) begin
                        rate_in = {b, rate_in[31:8]};
                     end else if (n == CNT_W'(14)) begin
                        bits_in[7:0] = b;
                     end else if (n == CNT_W'(15)) begin
                        bits_in[15:8] = b;
                     end
                     cnt_in = n1;
                     if ({{(32-CNT_W){1'b0}}, n1} >= len_in) begin
                        fmt_ok = ftag_in == FMT_PCM &&
                                 (chans_in == 16'd1 || chans_in == 16'd2) &&
                                 (bits_in == 16'd8 || bits_in == 16'd16) &&
                                 rate_in >= RATE_MIN && rate_in <= RATE_MAX;
                        if (!fmt_ok) begin
                           emit_valid  = 1'b1;
                           emit_status = STATUS_INVALID;
                        end else begin
                           phase_in = PH_DIV;
                           rem_in   = '0;
                           quo_in   = tick_in;
                           dcnt_in  = DCNT_W'(DIV_W - 1);
                        end
                     end
                  end
                  PH_SKIP: begin
                     if (len_in != '0) begin
                        len_in = len_in - 32'd1;
                     end else begin
                        pad_in = 1'b0;
                     end
                     if (len_in == '0 && !pad_in) begin
                        phase_in = PH_CHUNK;
                        cnt_in   = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
      end

      emit_item.status          = emit_status;
      emit_item.channels        = (align_in != '0) ? chans_in[1:0] : 2'd0;
      emit_item.bits_per_sample = (align_in != '0) ? bits_in[4:0] : 5'd0;
      emit_item.sample_period   = (align_in != '0) ? period_in : 8'd0;
      emit_item.data_size       = emit_size;
      emit_item.data_offset     = emit_offset;

      if (emit_valid) begin
         verdict_in   = 1'b1;
         rsp_valid_in = 1'b1;
         rsp_item_in  = emit_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         cnt_ff       <= '0;
         len_ff       <= '0;
         tag_ff       <= '0;
         pos_ff       <= '0;
         align_ff     <= '0;
         ftag_ff      <= '0;
         chans_ff     <= '0;
         rate_ff      <= '0;
         bits_ff      <= '0;
         period_ff    <= '0;
         verdict_ff   <= 1'b0;
         pad_ff       <= 1'b0;
         dcnt_ff      <= '0;
         tick_ff      <= TICK_RATE_RESET;
         min_ff       <= MIN_DATA_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         len_ff       <= len_in;
         tag_ff       <= tag_in;
         pos_ff       <= pos_in;
         align_ff     <= align_in;
         ftag_ff      <= ftag_in;
         chans_ff     <= chans_in;
         rate_ff      <= rate_in;
         bits_ff      <= bits_in;
         period_ff    <= period_in;
         verdict_ff   <= verdict_in;
         pad_ff       <= pad_in;
         dcnt_ff      <= dcnt_in;
         tick_ff      <= tick_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_item_ff <= rsp_item_in;
   end

   a_div_blocks_input: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DIV |-> !req_bus.ready)
      else $error("input taken while divider busy");

   a_align_legal: assert property (@(posedge clock) disable iff (reset)
      $onehot0(align_ff))
      else $error("frame alignment not 0, 1, 2 or 4");

   a_one_verdict: assert property (@(posedge clock) disable iff (reset)
      emit_valid |-> !verdict_ff || req_bus.data.new_file)
      else $error("second verdict for one file");

   a_ok_has_format: assert property (@(posedge clock) disable iff (reset)
      emit_valid && emit_item.status == STATUS_OK |-> emit_item.channels != 2'd0)
      else $error("ok verdict without format");

   a_div_finish: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DIV && dcnt_ff == '0 |=> phase_ff == PH_CHUNK && align_ff != '0)
      else $error("divider finish did not resume chunk walk");

endmodule

`default_nettype wire

@@ verif/wav_header_parser_unit_tb.sv @@
// Testbench for wav_header_parser_unit: streams RIFF/WAVE files byte by byte, predicts
// each verdict item with a parser of its own and compares every field.
// Depends on whp_pkg, whp_stream_if and the wav_header_parser_unit top level.

module wav_header_parser_unit_tb;
   import whp_pkg::*;

   localparam int unsigned FMT_MAX_BYTES  = 128;
   localparam int unsigned SETTLE_CYCLES  = 40;
   localparam int unsigned ITEM_TARGET    = 500;
   localparam int unsigned WHOLE_FILE     = 32'h4000_0000;
   localparam int unsigned MAX_REPORTS    = 40;
   localparam logic [31:0] TAG_RIFF       = 32'h4646_4952;
   localparam logic [31:0] TAG_LIST       = 32'h5453_494C;

   typedef enum logic [1:0] {PH_RIFF, PH_CHUNK_HDR, PH_FMT_BODY, PH_SKIP_BODY} parse_phase_type;
   typedef enum logic [1:0] {END_NONE, END_EOF, END_IOERR} file_ending_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TICK_W-1:0]    csr_wdata;

   whp_stream_if #(.item_type(req_item_type)) req_bus ();
   whp_stream_if #(.item_type(rsp_item_type)) rsp_bus ();

   wav_header_parser_unit #(.MAX_FMT_BYTES(FMT_MAX_BYTES)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [TICK_W-1:0] tick_hz;
   logic [MIN_W-1:0]  min_bytes;
   parse_phase_type   phase;
   logic [31:0]       sect_cnt;
   logic [31:0]       chunk_len;
   logic [31:0]       chunk_id;
   logic [31:0]       file_pos;
   logic [2:0]        frame_bytes;
   logic [15:0]       fmt_code;
   logic [15:0]       fmt_chans;
   logic [15:0]       fmt_bits;
   logic [31:0]       fmt_rate;
   logic [7:0]        fmt_period;
   logic              verdict_seen;
   logic              pad_pending;
   rsp_item_type      verdict_q[$];

   int unsigned fail_count;
   int unsigned items_sent;
   bit          gaps_on;
   bit          stalls_on;
   logic [7:0]  file_img[$];

   function automatic void clear_parser();
      phase        = PH_RIFF;
      sect_cnt     = '0;
      chunk_len    = '0;
      chunk_id     = '0;
      file_pos     = '0;
      frame_bytes  = '0;
      fmt_code     = '0;
      fmt_chans    = '0;
      fmt_bits     = '0;
      fmt_rate     = '0;
      fmt_period   = '0;
      verdict_seen = 1'b0;
      pad_pending  = 1'b0;
   endfunction

   function automatic void post_verdict(input logic [1:0] st, input logic [31:0] sz,
                                        input logic [31:0] off);
      rsp_item_type v;
      v.status          = st;
      v.channels        = (frame_bytes != 0) ? fmt_chans[1:0] : 2'd0;
      v.bits_per_sample = (frame_bytes != 0) ? fmt_bits[4:0] : 5'd0;
      v.sample_period   = (frame_bytes != 0) ? fmt_period : 8'd0;
      v.data_size       = sz;
      v.data_offset     = off;
      verdict_q.push_back(v);
      verdict_seen = 1'b1;
   endfunction

   function automatic void set_half(inout logic [15:0] f, input logic [31:0] idx,
                                    input logic [7:0] b);
      if (idx[0]) f[15:8] = b;
      else f[7:0] = b;
   endfunction

   function automatic void end_chunk_header();
      logic [32:0] rounded;
      logic [31:0] mask;
      rounded  = {1'b0, chunk_len} + chunk_len[0];
      mask     = {29'd0, frame_bytes} - 32'd1;
      sect_cnt = '0;
      if (chunk_id == TAG_FMT) begin
         if (rounded < FMT_MIN_BYTES || rounded > FMT_MAX_BYTES) begin
            post_verdict(STATUS_INVALID, '0, '0);
         end else begin
            chunk_len   = rounded[31:0];
            frame_bytes = '0;
            fmt_code    = '0;
            fmt_chans   = '0;
            fmt_bits    = '0;
            fmt_rate    = '0;
            fmt_period  = '0;
            phase       = PH_FMT_BODY;
         end
      end else if (chunk_id == TAG_DATA) begin
         if (frame_bytes == 0 || chunk_len < min_bytes || (chunk_len & mask) != 0 ||
             (file_pos & mask) != 0)
            post_verdict(STATUS_INVALID, '0, '0);
         else
            post_verdict(STATUS_OK, chunk_len, file_pos);
      end else begin
         pad_pending = chunk_len[0];
         phase       = (chunk_len == 0) ? PH_CHUNK_HDR : PH_SKIP_BODY;
      end
   endfunction

   function automatic void end_fmt_body();
      logic [31:0] quot;
      if (fmt_code != FMT_PCM || (fmt_chans != 1 && fmt_chans != 2) ||
          (fmt_bits != 8 && fmt_bits != 16) || fmt_rate < RATE_MIN || fmt_rate > RATE_MAX) begin
         post_verdict(STATUS_INVALID, '0, '0);
      end else begin
         quot        = ({8'd0, tick_hz} / fmt_rate) - 32'd1;
         fmt_period  = quot[7:0];
         frame_bytes = (fmt_bits == 16) ? {fmt_chans[1:0], 1'b0} : {1'b0, fmt_chans[1:0]};
         phase       = PH_CHUNK_HDR;
         sect_cnt    = '0;
      end
   endfunction

   function automatic void take_byte(input logic [7:0] b);
      logic [31:0] n;
      n        = sect_cnt;
      file_pos = file_pos + 32'd1;
      case (phase)
         PH_RIFF: begin
            if (n >= 8) chunk_id = {b, chunk_id[31:8]};
            sect_cnt = n + 32'd1;
            if (n == 11) begin
               if (chunk_id != TAG_WAVE) begin
                  post_verdict(STATUS_INVALID, '0, '0);
               end else begin
                  phase    = PH_CHUNK_HDR;
                  sect_cnt = '0;
               end
            end
         end
         PH_CHUNK_HDR: begin
            if (n < 4) chunk_id = {b, chunk_id[31:8]};
            else chunk_len = {b, chunk_len[31:8]};
            sect_cnt = n + 32'd1;
            if (n == 7) end_chunk_header();
         end
         PH_FMT_BODY: begin
            if (n < 2) set_half(fmt_code, n, b);
            else if (n < 4) set_half(fmt_chans, n, b);
            else if (n < 8) fmt_rate = {b, fmt_rate[31:8]};
            else if (n == 14 || n == 15) set_half(fmt_bits, n, b);
            sect_cnt = n + 32'd1;
            if (sect_cnt >= chunk_len) end_fmt_body();
         end
         default: begin
            if (chunk_len > 0) chunk_len = chunk_len - 32'd1;
            else pad_pending = 1'b0;
            if (chunk_len == 0 && !pad_pending) begin
               phase    = PH_CHUNK_HDR;
               sect_cnt = '0;
            end
         end
      endcase
   endfunction

   function automatic void predict_item(input req_item_type it);
      if (it.new_file) clear_parser();
      if (!verdict_seen) begin
         if (it.io_error) post_verdict(STATUS_IO_ERR, '0, '0);
         else if (it.stream_end) post_verdict(STATUS_INVALID, '0, '0);
         else take_byte(it.data_byte);
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // file image builders
   function automatic void push_le(input logic [31:0] v, input int unsigned nbytes);
      for (int k = 0; k < nbytes; k++) file_img.push_back(v[8*k +: 8]);
   endfunction

   function automatic void start_riff();
      file_img.delete();
      push_le(TAG_RIFF, 4);
      push_le($urandom, 4);
      push_le(TAG_WAVE, 4);
   endfunction

   function automatic void push_fmt(input logic [31:0] len, input logic [15:0] code,
                                    input logic [15:0] chans, input logic [31:0] rate,
                                    input logic [15:0] bits);
      logic [32:0] body_len;
      push_le(TAG_FMT, 4);
      push_le(len, 4);
      body_len = {1'b0, len} + len[0];
      if (body_len >= FMT_MIN_BYTES && body_len <= FMT_MAX_BYTES) begin
         push_le(32'(code), 2);
         push_le(32'(chans), 2);
         push_le(rate, 4);
         push_le($urandom, 4);
         push_le($urandom, 2);
         push_le(32'(bits), 2);
         repeat (body_len - FMT_MIN_BYTES) push_le($urandom, 1);
      end
   endfunction

   function automatic void push_skip(input logic [31:0] tag, input logic [31:0] len);
      push_le(tag, 4);
      push_le(len, 4);
      repeat (len + len[0]) push_le($urandom, 1);
   endfunction

   function automatic void push_data(input logic [31:0] len);
      push_le(TAG_DATA, 4);
      push_le(len, 4);
      repeat ($urandom_range(0, 3)) push_le($urandom, 1);
   endfunction

   function automatic void make_wav(input logic [31:0] fmt_len, input logic [15:0] code,
                                    input logic [15:0] chans, input logic [31:0] rate,
                                    input logic [15:0] bits, input logic [31:0] data_len);
      start_riff();
      push_fmt(fmt_len, code, chans, rate, bits);
      push_data(data_len);
   endfunction

   // result side: feeds the predictor with every accepted input item and checks every accepted verdict item
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) predict_item(req_bus.data);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (verdict_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: unexpected item, expected none, actual status %0d size %0h",
                           $time, rsp_bus.data.status, rsp_bus.data.data_size);
            end else begin
               want = verdict_q.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_bus.data.status));
               check_field("channels", 32'(want.channels), 32'(rsp_bus.data.channels));
               check_field("bits_per_sample", 32'(want.bits_per_sample),
                           32'(rsp_bus.data.bits_per_sample));
               check_field("sample_period", 32'(want.sample_period),
                           32'(rsp_bus.data.sample_period));
               check_field("data_size", want.data_size, rsp_bus.data.data_size);
               check_field("data_offset", want.data_offset, rsp_bus.data.data_offset);
            end
         end
      end
   end

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stalls_on && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic send_item(input req_item_type it);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= it;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic send_file(input int unsigned cut, input file_ending_type ending);
      req_item_type it;
      for (int unsigned i = 0; i < file_img.size() && i < cut; i++) begin
         it           = '0;
         it.data_byte = file_img[i];
         it.new_file  = (i == 0);
         send_item(it);
      end
      if (ending != END_NONE) begin
         it            = '0;
         it.data_byte  = $urandom_range(0, 255);
         it.new_file   = (cut == 0);
         it.stream_end = (ending == END_EOF) ? 1'b1 : 1'($urandom_range(0, 1));
         it.io_error   = (ending == END_IOERR);
         send_item(it);
      end
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input logic [TICK_W-1:0] tick, input logic [MIN_W-1:0] min_val);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_TICK_RATE;
      csr_wdata <= tick;
      @(posedge clock);
      csr_index <= CSR_MIN_DATA;
      csr_wdata <= {{(TICK_W-MIN_W){1'b0}}, min_val};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tick_hz   = tick;
      min_bytes = min_val;
   endtask

   task automatic test_valid_formats();
      make_wav(16, FMT_PCM, 1, RATE_MIN, 8, 1024);
      send_file(WHOLE_FILE, END_NONE);
      make_wav(16, FMT_PCM, 2, RATE_MAX, 16, 4096);
      send_file(WHOLE_FILE, END_NONE);
      start_riff();
      push_fmt(18, FMT_PCM, 2, 22050, 8);
      push_skip(TAG_LIST, 3);
      push_skip(TAG_LIST, 0);
      push_data(2048);
      send_file(WHOLE_FILE, END_NONE);
      make_wav(15, FMT_PCM, 1, 44100, 16, 1030);
      send_file(WHOLE_FILE, END_NONE);
      make_wav(FMT_MAX_BYTES, FMT_PCM, 2, 11025, 16, 32'h0001_0000);
      send_file(WHOLE_FILE, END_NONE);
   endtask

   task automatic test_header_errors();
      start_riff();
      file_img[8] = file_img[8] ^ 8'h01;
      push_fmt(16, FMT_PCM, 1, 8000, 8);
      send_file(WHOLE_FILE, END_NONE);
      make_wav(14, FMT_PCM, 1, 8000, 8, 2048);
      send_file(WHOLE_FILE, END_NONE);
      make_wav(FMT_MAX_BYTES + 1, FMT_PCM, 1, 8000, 8, 2048);
      send_file(WHOLE_FILE, END_NONE);
      make_wav(32'hFFFF_FFFF, FMT_PCM, 1, 8000, 8, 2048);
      send_file(WHOLE_FILE, END_NONE);
      make_wav(16, FMT_PCM, 1, RATE_MIN - 1, 8, 2048);
      send_file(WHOLE_FILE, END_NONE);
      make_wav(16, FMT_PCM, 1, RATE_MAX + 1, 8, 2048);
      send_file(WHOLE_FILE, END_NONE);
      make_wav(16, 16'd3, 1, 8000, 8, 2048);
      send_file(WHOLE_FILE, END_NONE);
      make_wav(16, FMT_PCM, 0, 8000, 8, 2048);
      send_file(WHOLE_FILE, END_NONE);
      make_wav(16, FMT_PCM, 3, 8000, 16, 2048);
      send_file(WHOLE_FILE, END_NONE);
      make_wav(16, FMT_PCM, 2, 8000, 24, 2048);
      send_file(WHOLE_FILE, END_NONE);
      start_riff();
      push_data(2048);
      send_file(WHOLE_FILE, END_NONE);
      start_riff();
      push_fmt(16, FMT_PCM, 2, 44100, 16);
      push_le(TAG_FMT, 4);
      push_le(16, 4);
      push_le($urandom, 4);
      send_file(WHOLE_FILE, END_EOF);
      make_wav(16, FMT_PCM, 1, 8000, 8, 1023);
      send_file(WHOLE_FILE, END_NONE);
      make_wav(16, FMT_PCM, 2, 8000, 16, 1026);
      send_file(WHOLE_FILE, END_NONE);
      make_wav(18, FMT_PCM, 2, 8000, 16, 2048);
      send_file(WHOLE_FILE, END_NONE);
      start_riff();
      push_fmt(16, FMT_PCM, 1, 16000, 8);
      push_le(TAG_LIST, 4);
      push_le(32'hFFFF_FFFF, 4);
      repeat (30) push_le($urandom, 1);
      send_file(WHOLE_FILE, END_EOF);
   endtask

   task automatic test_stream_flags();
      make_wav(16, FMT_PCM, 1, 8000, 8, 2048);
      send_file(20, END_IOERR);
      send_file(30, END_EOF);
      send_file(0, END_EOF);
      send_file(0, END_IOERR);
      send_file(25, END_NONE);
      send_file(WHOLE_FILE, END_IOERR);
      send_file(WHOLE_FILE, END_EOF);
      wait_idle();
   endtask

   task automatic test_config_extremes();
      write_settings('0, '0);
      make_wav(16, FMT_PCM, 1, 8000, 8, 0);
      send_file(WHOLE_FILE, END_NONE);
      write_settings('1, '1);
      make_wav(16, FMT_PCM, 2, 8000, 16, 32'h0001_0000);
      send_file(WHOLE_FILE, END_NONE);
      make_wav(16, FMT_PCM, 2, 8000, 16, 32'h0000_FFFC);
      send_file(WHOLE_FILE, END_NONE);
      write_settings(1, 1);
      make_wav(16, FMT_PCM, 1, 48000, 16, 2);
      send_file(WHOLE_FILE, END_NONE);
      write_settings(16_000_000, MIN_DATA_RESET);
      make_wav(16, FMT_PCM, 2, 48000, 8, 4096);
      send_file(WHOLE_FILE, END_NONE);
   endtask

   task automatic test_random_files();
      int unsigned      start_items;
      int unsigned      files;
      int unsigned      pick;
      logic [15:0]      chans;
      logic [15:0]      bits;
      logic [31:0]      rate;
      logic [31:0]      fmt_len;
      logic [31:0]      data_len;
      logic [2:0]       frame;
      logic [TICK_W-1:0] tick;
      logic [MIN_W-1:0]  min_val;
      req_item_type     it;
      start_items    = items_sent;
      files          = 0;
      while (items_sent - start_items < ITEM_TARGET) begin
         if (files % 4 == 3) begin
            case ($urandom_range(0, 3))
               0: tick = '1;
               1: tick = $urandom_range(0, 24'hFF_FFFF);
               2: tick = $urandom_range(8000, 16_000_000);
               default: tick = TICK_RATE_RESET;
            endcase
            case ($urandom_range(0, 3))
               0: min_val = '0;
               1: min_val = '1;
               2: min_val = $urandom_range(1, 2048);
               default: min_val = $urandom_range(0, 65535);
            endcase
            write_settings(tick, min_val);
         end
         if (items_sent - start_items > ITEM_TARGET * 4 / 5) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            chans = $urandom_range(1, 2);
            bits  = $urandom_range(0, 1) ? 16'd16 : 16'd8;
            case ($urandom_range(0, 9))
               0: rate = $urandom_range(7000, 49000);
               1: rate = $urandom_range(0, 1) ? RATE_MIN : RATE_MAX;
               default: rate = $urandom_range(RATE_MIN, RATE_MAX);
            endcase
            fmt_len = ($urandom_range(0, 3) == 0) ? $urandom_range(15, FMT_MAX_BYTES) : 16;
            frame   = (bits == 16) ? {chans[1:0], 1'b0} : {1'b0, chans[1:0]};
            data_len = ({16'd0, min_bytes} + $urandom_range(0, 4096)) &
                       ~({29'd0, frame} - 32'd1);
            if ($urandom_range(0, 7) == 0) data_len = $urandom;
            start_riff();
            repeat ($urandom_range(0, 2)) push_skip($urandom, $urandom_range(0, 9));
            push_fmt(fmt_len, FMT_PCM, chans, rate, bits);
            repeat ($urandom_range(0, 1)) push_skip($urandom, $urandom_range(0, 9));
            push_data(data_len);
            if (pick >= 60 && pick < 70)
               file_img[$urandom_range(0, file_img.size() - 1)] = $urandom_range(0, 255);
            if (pick >= 70)
               send_file($urandom_range(0, file_img.size() - 1),
                         $urandom_range(0, 1) ? END_EOF : END_IOERR);
            else
               send_file(WHOLE_FILE, END_NONE);
         end else begin
            repeat ($urandom_range(1, 20)) begin
               it.data_byte  = $urandom_range(0, 255);
               it.new_file   = ($urandom_range(0, 7) == 0);
               it.stream_end = ($urandom_range(0, 15) == 0);
               it.io_error   = ($urandom_range(0, 15) == 0);
               send_item(it);
            end
         end
         files++;
      end
   endtask

   initial begin
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_TICK_RATE;
      csr_wdata     = '0;
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      fail_count    = 0;
      items_sent    = 0;
      gaps_on       = 1'b1;
      stalls_on     = 1'b1;
      tick_hz       = TICK_RATE_RESET;
      min_bytes     = MIN_DATA_RESET;
      clear_parser();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_valid_formats();
      test_header_errors();
      test_stream_flags();
      test_config_extremes();
      test_random_files();

      req_bus.valid <= 1'b0;
      for (int k = 0; k < 5000 && verdict_q.size() != 0; k++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (verdict_q.size() != 0) begin
         fail_count++;
         $display("%0t: %0d expected items never arrived", $time, verdict_q.size());
      end
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
